>>> rtl/core/byte_stream_reassembler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte stream reassembler
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_REASSEMBLER_DEFINES_SVH
`define BYTE_STREAM_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("reassembler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("reassembler check failed");

`endif

>>> rtl/core/bsr_pkg.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler package
// Sizes, command codes, controller states and payload types.
// ----------------------------------------------------------------------------
package bsr_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_END  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH_WR,
		ST_ADV_RD,
		ST_ADV_CHK,
		ST_SWEEP,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] stream_index;
		logic [7:0]  data_byte;
	} cmd_t;

	typedef struct packed {
		logic        read_valid;
		logic [7:0]  read_byte;
		logic [10:0] pending_bytes;
		logic [10:0] buffered_bytes;
		logic        input_ended;
		logic        stream_finished;
	} res_t;

endpackage

>>> rtl/core/bsr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module bsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/byte_stream_reassembler.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler
// Out-of-order byte reassembly over a ring of CAPACITY bytes.
// ----------------------------------------------------------------------------
// Steps: status and dropped items go straight to the done state; reads wait
// on the ring read; pushes write the byte, then advance over contiguous valid
// slots up to any end; end markers sweep the window past the end.
// Throughput: one item at a time; the valid-map memory's read port paces
// the sweep and advance steps.
// Reset: control clears at once, then a pass over all CAPACITY slots clears
// the valid map with busy high. The receiver cannot stall results.
module byte_stream_reassembler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bsr_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output bsr_pkg::res_t result
);
	import bsr_pkg::*;

	state_t state_q, state_d;

	logic [31:0] rd_q, asm_q, end_q;
	logic        end_known_q;
	logic [10:0] pending_q;
	logic [ADDR_W-1:0] clr_q, slot_q;
	logic [7:0]  byte_q;
	logic [CNT_W-1:0] cnt_q, lim_q;
	logic        sweep_s1;
	logic [ADDR_W-1:0] sweep_slot_s1;
	logic        rv_q;
	logic [7:0]  rb_q;
	res_t        result_q;
	logic        done_q;

	logic        v_we, v_wdata, v_rdata;
	logic [ADDR_W-1:0] v_waddr, v_raddr;
	logic        b_we;
	logic [7:0]  b_rdata;
	logic [ADDR_W-1:0] b_raddr;

	logic [31:0] off, room, buffered;
	logic        ended;
	logic        accept;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign off      = cmd.stream_index - asm_q;
	assign room     = 32'(CAPACITY) - (asm_q - rd_q);
	assign buffered = asm_q - rd_q;
	// The end is reached exactly when assembly sits on a known end position.
	assign ended    = end_known_q && (asm_q == end_q);

	bsr_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_valid (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	bsr_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ring (
		.clk(clk), .we(b_we), .waddr(slot_q), .wdata(byte_q),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	assign b_we    = (state_q == ST_PUSH_WR) && !v_rdata;
	assign b_raddr = rd_q[ADDR_W-1:0];

	always_comb begin
		state_d = state_q;
		v_we    = 1'b0;
		v_wdata = 1'b0;
		v_waddr = slot_q;
		v_raddr = asm_q[ADDR_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				v_we    = 1'b1;
				v_waddr = clr_q;
				if (clr_q == ADDR_W'(CAPACITY - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				v_raddr = cmd.stream_index[ADDR_W-1:0];
				if (accept) begin
					state_d = ST_DONE;
					case (cmd.op)
						OP_PUSH: begin
							if (off < room && !(end_known_q && off >= (end_q - asm_q)))
								state_d = ST_PUSH_WR;
						end
						OP_END: begin
							if (!end_known_q && off <= room) state_d = ST_SWEEP;
						end
						OP_READ: begin
							if (asm_q != rd_q) state_d = ST_READ_WAIT;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_PUSH_WR: begin
				v_we    = !v_rdata;
				v_wdata = 1'b1;
				state_d = ST_ADV_RD;
			end
			ST_ADV_RD: begin
				state_d = ended ? ST_DONE : ST_ADV_CHK;
			end
			ST_ADV_CHK: begin
				v_we    = v_rdata;
				v_waddr = asm_q[ADDR_W-1:0];
				state_d = v_rdata ? ST_ADV_RD : ST_DONE;
			end
			ST_SWEEP: begin
				v_raddr = asm_q[ADDR_W-1:0] + cnt_q[ADDR_W-1:0];
				v_we    = sweep_s1 && v_rdata;
				v_waddr = sweep_slot_s1;
				if (cnt_q >= lim_q && !sweep_s1) state_d = ST_DONE;
			end
			ST_READ_WAIT: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_q        <= '0;
			asm_q       <= '0;
			end_q       <= '0;
			end_known_q <= 1'b0;
			pending_q   <= '0;
			sweep_s1    <= 1'b0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
			lim_q       <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DONE);
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						slot_q <= cmd.stream_index[ADDR_W-1:0];
						byte_q <= cmd.data_byte;
						rv_q   <= 1'b0;
						rb_q   <= '0;
						if (cmd.op == OP_END && !end_known_q && off <= room) begin
							end_known_q <= 1'b1;
							end_q       <= cmd.stream_index;
							cnt_q       <= off[CNT_W-1:0];
							lim_q       <= room[CNT_W-1:0];
							sweep_s1    <= 1'b0;
						end
					end
				end
				ST_PUSH_WR: begin
					if (!v_rdata) pending_q <= pending_q + 1'b1;
				end
				ST_ADV_CHK: begin
					if (v_rdata) begin
						asm_q     <= asm_q + 1'b1;
						pending_q <= pending_q - 1'b1;
					end
				end
				ST_SWEEP: begin
					// Each slot's valid bit comes back in the cycle after its read.
					sweep_s1      <= (cnt_q < lim_q);
					sweep_slot_s1 <= v_raddr;
					if (cnt_q < lim_q) cnt_q <= cnt_q + 1'b1;
					if (sweep_s1 && v_rdata) pending_q <= pending_q - 1'b1;
				end
				ST_READ_WAIT: begin
					rv_q <= 1'b1;
					rb_q <= b_rdata;
					rd_q <= rd_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			result_q.read_valid      <= rv_q;
			result_q.read_byte       <= rb_q;
			result_q.pending_bytes   <= pending_q;
			result_q.buffered_bytes  <= buffered[10:0];
			result_q.input_ended     <= ended;
			result_q.stream_finished <= ended && (buffered == 32'd0);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/bsr_checker.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_stream_reassembler_defines.svh"

module bsr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input bsr_pkg::res_t result
);
	import bsr_pkg::*;

	// An accepted transfer always takes the block out of idle.
	`BSR_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`BSR_ASSERT_NEXT(a_no_instant_result, clk, arst_n, start && !busy, !done)
	`BSR_ASSERT_NOW(a_empty_read_zero, clk, arst_n, done && !result.read_valid, result.read_byte == 8'd0)
	`BSR_ASSERT_NOW(a_finished_ended, clk, arst_n, done && result.stream_finished, result.input_ended && result.buffered_bytes == 11'd0)
	`BSR_ASSERT_NOW(a_counts_bounded, clk, arst_n, done, result.pending_bytes <= 11'(CAPACITY) && result.buffered_bytes <= 11'(CAPACITY))

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

>>> tb/byte_stream_reassembler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte stream reassembler testbench
// Drives pushes, end markers, reads and status commands through the start and
// busy handshake, and keeps its own copy of the ring and the counters. Every
// result is checked field by field against that copy or a typed row's value.
// Directed rows come first, then windowed random traffic, then a stream end.
// ----------------------------------------------------------------------------
module byte_stream_reassembler_test;
	import bsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int RANDOM_ITEMS   = 1300;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t exp;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	cmd_t  cmd;
	logic  busy;
	logic  done;
	res_t  result;

	// Shadow copy of the reassembler state.
	logic [7:0]  ring_copy [CAPACITY];
	bit          slot_valid [CAPACITY];
	logic [31:0] rd_cnt, asm_cnt, end_pos;
	bit          end_seen, ended;
	int          pend_cnt;

	res_t expected_q [$];
	int   error_count;
	int   idle_cycles;
	int   accepted_count;
	int   read_hits;
	int   drop_count;
	bit   no_idle;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	byte_stream_reassembler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	function automatic logic [31:0] free_room();
		return CAPACITY - (asm_cnt - rd_cnt);
	endfunction

	function automatic void advance_run();
		for (int n = 0; n < CAPACITY; n++) begin
			if (end_seen && asm_cnt == end_pos)
				break;
			if (!slot_valid[asm_cnt % CAPACITY])
				break;
			slot_valid[asm_cnt % CAPACITY] = 0;
			pend_cnt--;
			asm_cnt++;
		end
		if (end_seen && asm_cnt == end_pos)
			ended = 1;
	endfunction

	function automatic void store_byte(logic [31:0] idx, logic [7:0] b);
		logic [31:0] off;
		off = idx - asm_cnt;
		if (off >= free_room()) begin
			drop_count++;
			return;
		end
		if (end_seen && off >= end_pos - asm_cnt) begin
			drop_count++;
			return;
		end
		if (!slot_valid[idx % CAPACITY]) begin
			slot_valid[idx % CAPACITY] = 1;
			ring_copy[idx % CAPACITY] = b;
			pend_cnt++;
		end
		advance_run();
	endfunction

	function automatic void mark_end(logic [31:0] idx);
		logic [31:0] off, room;
		off  = idx - asm_cnt;
		room = free_room();
		if (end_seen || off > room)
			return;
		end_seen = 1;
		end_pos  = idx;
		// Pending bytes at or past the end are thrown away.
		for (logic [31:0] k = off; k < room; k++) begin
			if (slot_valid[(asm_cnt + k) % CAPACITY]) begin
				slot_valid[(asm_cnt + k) % CAPACITY] = 0;
				pend_cnt--;
			end
		end
		if (asm_cnt == end_pos)
			ended = 1;
	endfunction

	function automatic res_t reassemble(cmd_t c);
		res_t r;
		logic [31:0] buffered;
		r = '0;
		case (c.op)
			OP_PUSH: store_byte(c.stream_index, c.data_byte);
			OP_END:  mark_end(c.stream_index);
			OP_READ: begin
				if (asm_cnt != rd_cnt) begin
					r.read_valid = 1'b1;
					r.read_byte  = ring_copy[rd_cnt % CAPACITY];
					rd_cnt++;
					read_hits++;
				end
			end
			default: ;
		endcase
		buffered = asm_cnt - rd_cnt;
		r.pending_bytes   = pend_cnt[10:0];
		r.buffered_bytes  = buffered[10:0];
		r.input_ended     = ended;
		r.stream_finished = ended && buffered == 0;
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] op, logic [31:0] idx, logic [7:0] b);
		cmd_t c;
		c.op           = op;
		c.stream_index = idx;
		c.data_byte    = b;
		return c;
	endfunction

	function automatic res_t make_res(bit rv, logic [7:0] rb, int pend, int buf_n);
		res_t r;
		r = '0;
		r.read_valid     = rv;
		r.read_byte      = rb;
		r.pending_bytes  = pend[10:0];
		r.buffered_bytes = buf_n[10:0];
		return r;
	endfunction

	// Hands one command over and records its expected status once the transfer
	// has happened. The start line stays high between back-to-back commands.
	task automatic send_cmd(cmd_t c, bit typed, res_t typed_exp);
		int gap;
		res_t predicted;
		gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		predicted = reassemble(c);
		expected_q.push_back(typed ? typed_exp : predicted);
		accepted_count++;
	endtask

	task automatic send(cmd_t c);
		send_cmd(c, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (expected_q.size() == 0) begin
				$error("result with no command outstanding");
				error_count++;
			end else begin
				res_t e;
				e = expected_q.pop_front();
				if (result.read_valid !== e.read_valid) begin
					$error("read_valid: expected %0d, got %0d", e.read_valid, result.read_valid);
					error_count++;
				end
				if (result.read_byte !== e.read_byte) begin
					$error("read_byte: expected %0h, got %0h", e.read_byte, result.read_byte);
					error_count++;
				end
				if (result.pending_bytes !== e.pending_bytes) begin
					$error("pending_bytes: expected %0d, got %0d",
						e.pending_bytes, result.pending_bytes);
					error_count++;
				end
				if (result.buffered_bytes !== e.buffered_bytes) begin
					$error("buffered_bytes: expected %0d, got %0d",
						e.buffered_bytes, result.buffered_bytes);
					error_count++;
				end
				if (result.input_ended !== e.input_ended) begin
					$error("input_ended: expected %0d, got %0d",
						e.input_ended, result.input_ended);
					error_count++;
				end
				if (result.stream_finished !== e.stream_finished) begin
					$error("stream_finished: expected %0d, got %0d",
						e.stream_finished, result.stream_finished);
					error_count++;
				end
			end
		end
	end

	// Counts cycles in which neither a command nor a result is transferred.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		row_t dir_rows [$];
		cmd_t c;
		logic [1:0] op;
		logic [31:0] idx, base;
		int pick, fill_bias;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		error_count = 0;
		idle_cycles = 0;
		accepted_count = 0;
		read_hits = 0;
		drop_count = 0;
		no_idle = 0;
		rd_cnt = 0;
		asm_cnt = 0;
		end_pos = 0;
		end_seen = 0;
		ended = 0;
		pend_cnt = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			slot_valid[i] = 0;
			ring_copy[i] = '0;
		end

		dir_rows = '{
			'{make_cmd(OP_NOP,  32'd0,          8'h00), 1, make_res(0, 8'h00, 0, 0)},
			'{make_cmd(OP_READ, 32'd0,          8'h00), 1, make_res(0, 8'h00, 0, 0)},
			'{make_cmd(OP_PUSH, 32'd0,          8'hFF), 1, make_res(0, 8'h00, 0, 1)},
			'{make_cmd(OP_READ, 32'hFFFF_FFFF,  8'hFF), 1, make_res(1, 8'hFF, 0, 0)},
			'{make_cmd(OP_PUSH, 32'hFFFF_FFFF,  8'h00), 1, make_res(0, 8'h00, 0, 0)},
			'{make_cmd(OP_PUSH, 32'd1025,       8'h77), 1, make_res(0, 8'h00, 0, 0)},
			'{make_cmd(OP_PUSH, 32'd1024,       8'hA5), 1, make_res(0, 8'h00, 1, 0)},
			'{make_cmd(OP_PUSH, 32'd1024,       8'h5A), 1, make_res(0, 8'h00, 1, 0)},
			'{make_cmd(OP_PUSH, 32'd3,          8'h11), 0, '0},
			'{make_cmd(OP_END,  32'd0,          8'h00), 0, '0},
			'{make_cmd(OP_END,  32'd1026,       8'h00), 0, '0},
			'{make_cmd(OP_END,  32'h8000_0000,  8'h00), 0, '0},
			'{make_cmd(OP_PUSH, 32'd1,          8'h22), 0, '0},
			'{make_cmd(OP_PUSH, 32'd2,          8'h33), 0, '0},
			'{make_cmd(OP_READ, 32'd0,          8'h00), 0, '0},
			'{make_cmd(OP_READ, 32'd0,          8'h00), 0, '0},
			'{make_cmd(OP_READ, 32'd0,          8'h00), 0, '0},
			'{make_cmd(OP_READ, 32'd0,          8'h00), 0, '0},
			'{make_cmd(OP_NOP,  32'h5555_AAAA,  8'h3C), 0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].exp);

		fill_bias = 20;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Every 100 items, pick at random between filling the ring and draining it.
			if (n % 100 == 0) begin
				fill_bias = $urandom_range(0, 1) ? 10 : 60;
				no_idle = $urandom_range(0, 3) == 0;
			end
			if (n == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				wait (expected_q.size() == 0);
				@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			idx = $urandom;
			if (pick < fill_bias) begin
				op = OP_READ;
			end else if (pick < 90) begin
				op = OP_PUSH;
				case ($urandom_range(0, 9))
					0: idx = rd_cnt + CAPACITY - 1;
					1: idx = rd_cnt + CAPACITY;
					2: idx = asm_cnt - $urandom_range(1, 8);
					3: idx = $urandom;
					default: idx = asm_cnt + $urandom_range(0, 24);
				endcase
			end else if (pick < 95) begin
				op = OP_END;
				// Only end markers that the block must ignore during the bulk run.
				idx = $urandom_range(0, 1) ? asm_cnt - $urandom_range(1, 64)
					: rd_cnt + CAPACITY + $urandom_range(1, 64);
			end else begin
				op = OP_NOP;
			end
			send(make_cmd(op, idx, 8'($urandom)));
		end

		// Closing sequence: drain, leave a gap, then finish the stream.
		while (asm_cnt != rd_cnt)
			send(make_cmd(OP_READ, $urandom, 8'($urandom)));
		base = asm_cnt;
		send(make_cmd(OP_PUSH, base + 3, 8'($urandom)));
		send(make_cmd(OP_PUSH, base + 6, 8'($urandom)));
		send(make_cmd(OP_PUSH, base + 9, 8'($urandom)));
		send(make_cmd(OP_END,  base + 5, 8'h00));
		send(make_cmd(OP_END,  base + 8, 8'h00));
		send(make_cmd(OP_PUSH, base + 5, 8'($urandom)));
		for (int k = 0; k < 5; k++)
			send(make_cmd(OP_PUSH, base + k, 8'($urandom)));
		send(make_cmd(OP_PUSH, base + 4, 8'($urandom)));
		for (int k = 0; k < 6; k++)
			send(make_cmd(OP_READ, 32'd0, 8'h00));
		send(make_cmd(OP_NOP, 32'd0, 8'h00));

		start <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (20) @(posedge clk);
		$display("Covered %0d commands: %0d bytes read back, %0d pushes dropped.",
			accepted_count, read_hits, drop_count);
		$display("Ran windowed out-of-order pushes, duplicates, ignored and final end markers.");
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
